// ----- hdl/wsaf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsaf_pkg
// Shared widths, constants, command codes and control structs for the
// sufficiency filter.
// ----------------------------------------------------------------------------
package wsaf_pkg;

    localparam int MASK_W   = 64;
    localparam int CNT_W    = 21;
    localparam int CARD_W   = 7;
    localparam int Q_W      = 31;
    localparam int TOT_W    = 32;
    localparam int Z_W      = 31;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 64;

    localparam logic [CNT_W-1:0] MAX_ROWS = 21'd1048576;
    localparam logic [Q_W-1:0]   ONE_Q30  = 31'h4000_0000;
    localparam logic [Q_W-1:0]   THETA_RST = 31'd1073741824;
    localparam logic [Z_W-1:0]   Z_RST     = 31'd526083000;

    // Long divider: numerator below 2^51 shifted left by up to 40 bits.
    localparam int DEN_W     = 50;
    localparam int NUM_W     = 51;
    localparam int DVD_W     = 81;
    localparam int DIV_STEPS = 81;
    localparam int DIV_CNT_W = 7;
    localparam int QUO_W     = 64;
    localparam int SQ_W      = 64;
    localparam int SQ_K_W    = 5;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 184;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_THETA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Z     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MONLY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXCL  = 3'd4;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_MUL_Z2,
        CMD_MUL_PROD,
        CMD_DIV_RAD,
        CMD_SQRT,
        CMD_MUL_MARG,
        CMD_NUMR,
        CMD_DIV_LB,
        CMD_DIV_GATE,
        CMD_MUL_TN,
        CMD_SCAN,
        CMD_COMMIT,
        CMD_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    idle;
    } ctrl_cmd_t;

    typedef struct packed {
        logic finish;
        logic excluded;
        logic n_zero;
        logic crit;
        logic suff;
        logic emit;
        logic out_free;
        logic div_done;
        logic sqrt_done;
        logic scan_done;
    } dp_status_t;

endpackage

// ----- hdl/wsaf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsaf_ctrl
// Sequencer that walks one item through the datapath steps.
// ----------------------------------------------------------------------------
module wsaf_ctrl
    import wsaf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_accept,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_Z2,
        S_MUL_PROD,
        S_DIV_RAD,
        S_SQRT,
        S_MUL_MARG,
        S_NUMR,
        S_DIV_LB,
        S_DIV_GATE,
        S_MUL_TN,
        S_DECIDE,
        S_SCAN,
        S_COMMIT,
        S_EMIT
    } state_t;

    state_t  state_reg, state_next;
    cmd_op_t op_reg, op_next;
    logic    idle_reg, idle_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                priority if (status.finish)
                begin
                    state_next = S_EMIT;
                    op_next    = CMD_EMIT;
                end
                else if (status.excluded)
                    state_next = S_IDLE;
                else
                begin
                    state_next = S_MUL_Z2;
                    op_next    = CMD_MUL_Z2;
                end
            end
            S_MUL_Z2:
            begin
                priority if (!status.n_zero)
                begin
                    state_next = S_MUL_PROD;
                    op_next    = CMD_MUL_PROD;
                end
                else if (status.crit)
                begin
                    state_next = S_MUL_TN;
                    op_next    = CMD_MUL_TN;
                end
                else
                    state_next = S_DECIDE;
            end
            S_MUL_PROD:
            begin
                state_next = S_DIV_RAD;
                op_next    = CMD_DIV_RAD;
            end
            S_DIV_RAD:
            begin
                if (status.div_done)
                begin
                    state_next = S_SQRT;
                    op_next    = CMD_SQRT;
                end
            end
            S_SQRT:
            begin
                if (status.sqrt_done)
                begin
                    state_next = S_MUL_MARG;
                    op_next    = CMD_MUL_MARG;
                end
            end
            S_MUL_MARG:
            begin
                state_next = S_NUMR;
                op_next    = CMD_NUMR;
            end
            S_NUMR:
            begin
                state_next = S_DIV_LB;
                op_next    = CMD_DIV_LB;
            end
            S_DIV_LB:
            begin
                if (status.div_done)
                begin
                    if (status.crit)
                    begin
                        state_next = S_MUL_TN;
                        op_next    = CMD_MUL_TN;
                    end
                    else
                    begin
                        state_next = S_DIV_GATE;
                        op_next    = CMD_DIV_GATE;
                    end
                end
            end
            S_DIV_GATE:
            begin
                if (status.div_done)
                    state_next = S_DECIDE;
            end
            S_MUL_TN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.suff)
                begin
                    state_next = S_SCAN;
                    op_next    = CMD_SCAN;
                end
                else
                    state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = S_COMMIT;
                    op_next    = CMD_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (status.emit)
                begin
                    state_next = S_EMIT;
                    op_next    = CMD_EMIT;
                end
                else
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
                else
                    op_next = CMD_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        idle_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= CMD_NONE;
            idle_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            idle_reg  <= idle_next;
        end
    end

    assign cmd.op   = op_reg;
    assign cmd.idle = idle_reg;

endmodule

// ----- hdl/wsaf_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsaf_dp
// Datapath: registers, shared multiplier, long divider, square root unit,
// antichain store with subset scan, and the result register.
// ----------------------------------------------------------------------------
module wsaf_dp
    import wsaf_pkg::*;
#(
    parameter int MAX_MINIMAL = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  in_accept,
    input  logic                  in_action,
    input  logic [MASK_W-1:0]     in_mask,
    input  logic [CNT_W-1:0]      in_support,
    input  logic [CNT_W-1:0]      in_hits,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  out_kind,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam int AW = (MAX_MINIMAL > 1) ? $clog2(MAX_MINIMAL) : 1;
    localparam int FW = $clog2(MAX_MINIMAL + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(MAX_MINIMAL);

    typedef enum logic [1:0] {DST_RAD, DST_LB, DST_GATE} div_dst_t;

    function automatic logic [CARD_W-1:0] pop64(input logic [MASK_W-1:0] v);
        logic [CARD_W-1:0] c;
        c = '0;
        for (int i = 0; i < MASK_W; i++)
            c = c + CARD_W'(v[i]);
        return c;
    endfunction

    // Configuration registers.
    logic [Q_W-1:0]    theta_reg;
    logic [Z_W-1:0]    z_reg;
    logic              crit_reg;
    logic              monly_reg;
    logic [MASK_W-1:0] excl_reg;

    // Item registers.
    logic              action_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [CNT_W-1:0]  sup_reg, hit_reg, n_reg, y_reg;
    logic [CARD_W-1:0] card_reg;
    logic [CNT_W-1:0]  n_in, y_in;

    // Arithmetic registers.
    logic [61:0]       z2_reg;
    logic [63:0]       mul_reg;
    logic [QUO_W-1:0]  rad_reg;
    logic [NUM_W-1:0]  numr_reg;
    logic [Q_W-1:0]    lb_reg;
    logic              gate_ok_reg;

    // Divider.
    logic [DVD_W-1:0]     dvd_reg;
    logic [DEN_W-1:0]     dden_reg, rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic                 dbusy_reg, ddone_reg;
    div_dst_t             ddst_reg;

    // Square root.
    logic [SQ_W-1:0]   sq_x_reg, sq_r_reg;
    logic [SQ_K_W-1:0] sq_k_reg;
    logic              sq_busy_reg, sq_done_reg;

    // Antichain store and scan.
    logic [MASK_W-1:0] store_mem [MAX_MINIMAL];
    logic [MASK_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic [FW-1:0]     sc_idx_reg, fill_reg;
    logic              sc_act_reg, sc_done_reg, hit_found_reg;
    logic [TOT_W-1:0]  total_reg;
    logic              ovf_reg;

    logic              out_valid_reg, out_kind_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign n_in = (in_support > MAX_ROWS) ? MAX_ROWS : in_support;
    assign y_in = (in_hits > n_in) ? n_in : in_hits;

    // Shared multiplier.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            CMD_MUL_Z2:
            begin
                mul_a = 32'(z_reg);
                mul_b = 32'(z_reg);
            end
            CMD_MUL_PROD:
            begin
                mul_a = 32'(y_reg);
                mul_b = 32'(n_reg - y_reg);
            end
            CMD_MUL_MARG:
            begin
                mul_a = 32'(z_reg);
                mul_b = sq_r_reg[31:0];
            end
            CMD_MUL_TN:
            begin
                mul_a = 32'(theta_reg);
                mul_b = 32'(n_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // Denominator (n + z^2) in Q.28.
    logic [DEN_W-1:0] den_c;
    assign den_c = DEN_W'({n_reg, 28'b0}) + DEN_W'(z2_reg[61:28]);

    // Divider step.
    logic [DEN_W:0]    trial;
    logic              qbit;
    logic [QUO_W-1:0]  quo_next;
    logic [Q_W-1:0]    quo_sat;
    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign qbit     = (trial >= {1'b0, dden_reg});
    assign quo_next = {quo_reg[QUO_W-2:0], qbit};
    assign quo_sat  = (quo_next > QUO_W'(ONE_Q30)) ? ONE_Q30 : quo_next[Q_W-1:0];

    // Square root step.
    logic [SQ_W-1:0] sq_bit, sq_t;
    assign sq_bit = SQ_W'(1) << {sq_k_reg, 1'b0};
    assign sq_t   = sq_r_reg + sq_bit;

    // Numerator of the bound: center minus rounded-up margin, floored at zero.
    logic [63:0] cent_c, marg_c;
    assign cent_c = 64'({y_reg, 28'b0}) + 64'(z2_reg[61:29]);
    assign marg_c = (mul_reg + 64'h0000_0000_000F_FFFF) >> 20;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theta_reg <= THETA_RST;
            z_reg     <= Z_RST;
            crit_reg  <= 1'b0;
            monly_reg <= 1'b0;
            excl_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THETA: theta_reg <= cfg_data[Q_W-1:0];
                REG_Z:     z_reg     <= cfg_data[Z_W-1:0];
                REG_CRIT:  crit_reg  <= cfg_data[0];
                REG_MONLY: monly_reg <= cfg_data[0];
                REG_EXCL:  excl_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= in_action;
            mask_reg   <= in_mask;
            sup_reg    <= in_support;
            hit_reg    <= in_hits;
            n_reg      <= n_in;
            y_reg      <= y_in;
            card_reg   <= pop64(in_mask);
        end
        if (cmd.op == CMD_MUL_Z2)
            z2_reg <= mul_p[61:0];
        if (cmd.op == CMD_MUL_PROD || cmd.op == CMD_MUL_MARG || cmd.op == CMD_MUL_TN)
            mul_reg <= mul_p;
        if (cmd.op == CMD_NUMR)
            numr_reg <= (cent_c > marg_c) ? NUM_W'(cent_c - marg_c) : '0;
    end

    // Divider and result destinations.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg   <= 1'b0;
            ddone_reg   <= 1'b0;
            dcnt_reg    <= '0;
            ddst_reg    <= DST_RAD;
            lb_reg      <= '0;
            gate_ok_reg <= 1'b0;
        end
        else
        begin
            ddone_reg <= 1'b0;
            if (in_accept)
                lb_reg <= '0;
            if (cmd.op == CMD_DIV_RAD || cmd.op == CMD_DIV_LB || cmd.op == CMD_DIV_GATE)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= DIV_CNT_W'(DIV_STEPS);
                rem_reg   <= '0;
                quo_reg   <= '0;
                unique case (cmd.op)
                    CMD_DIV_RAD:
                    begin
                        ddst_reg <= DST_RAD;
                        dvd_reg  <= DVD_W'({mul_reg[38:0], 40'b0});
                        dden_reg <= DEN_W'(n_reg);
                    end
                    CMD_DIV_LB:
                    begin
                        ddst_reg <= DST_LB;
                        dvd_reg  <= {numr_reg, 30'b0};
                        dden_reg <= den_c;
                    end
                    default:
                    begin
                        ddst_reg <= DST_GATE;
                        dvd_reg  <= {NUM_W'({n_reg, 28'b0}), 30'b0};
                        dden_reg <= den_c;
                    end
                endcase
            end
            else if (dbusy_reg)
            begin
                rem_reg  <= qbit ? DEN_W'(trial - {1'b0, dden_reg}) : trial[DEN_W-1:0];
                dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
                quo_reg  <= quo_next;
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == DIV_CNT_W'(1))
                begin
                    dbusy_reg <= 1'b0;
                    ddone_reg <= 1'b1;
                    unique case (ddst_reg)
                        DST_RAD:  rad_reg     <= quo_next;
                        DST_LB:   lb_reg      <= quo_sat;
                        DST_GATE: gate_ok_reg <= (quo_sat >= theta_reg);
                        default:  ;
                    endcase
                end
            end
        end
    end

    // Square root, one result bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            sq_k_reg    <= '0;
        end
        else
        begin
            sq_done_reg <= 1'b0;
            if (cmd.op == CMD_SQRT)
            begin
                sq_busy_reg <= 1'b1;
                sq_k_reg    <= '1;
                sq_x_reg    <= rad_reg + SQ_W'(z2_reg[61:18]);
                sq_r_reg    <= '0;
            end
            else if (sq_busy_reg)
            begin
                if (sq_x_reg >= sq_t)
                begin
                    sq_x_reg <= sq_x_reg - sq_t;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit;
                end
                else
                    sq_r_reg <= sq_r_reg >> 1;
                sq_k_reg <= sq_k_reg - 1'b1;
                if (sq_k_reg == '0)
                begin
                    sq_busy_reg <= 1'b0;
                    sq_done_reg <= 1'b1;
                end
            end
        end
    end

    // Subset scan: one stored mask read per cycle, compared the cycle after.
    always_ff @(posedge clk)
    begin
        if (sc_act_reg && sc_idx_reg < fill_reg)
            rd_data_reg <= store_mem[sc_idx_reg[AW-1:0]];
        if (cmd.op == CMD_COMMIT && !hit_found_reg && fill_reg < FILL_MAX)
            store_mem[fill_reg[AW-1:0]] <= mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_act_reg    <= 1'b0;
            sc_done_reg   <= 1'b0;
            sc_idx_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            hit_found_reg <= 1'b0;
        end
        else
        begin
            sc_done_reg <= 1'b0;
            if (cmd.op == CMD_SCAN)
            begin
                sc_act_reg    <= 1'b1;
                sc_idx_reg    <= '0;
                rd_vld_reg    <= 1'b0;
                hit_found_reg <= 1'b0;
            end
            else if (sc_act_reg)
            begin
                if (sc_idx_reg < fill_reg)
                begin
                    rd_vld_reg <= 1'b1;
                    sc_idx_reg <= sc_idx_reg + 1'b1;
                end
                else
                    rd_vld_reg <= 1'b0;
                if (rd_vld_reg && (rd_data_reg & mask_reg) == rd_data_reg)
                    hit_found_reg <= 1'b1;
                if (sc_idx_reg == fill_reg && !rd_vld_reg)
                begin
                    sc_act_reg  <= 1'b0;
                    sc_done_reg <= 1'b1;
                end
            end
        end
    end

    // Cell state and the result register.
    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.op == CMD_COMMIT)
            begin
                if (total_reg != '1)
                    total_reg <= total_reg + 1'b1;
                if (!hit_found_reg)
                begin
                    if (fill_reg < FILL_MAX)
                        fill_reg <= fill_reg + 1'b1;
                    else
                        ovf_reg <= 1'b1;
                end
            end
            if (cmd.op == CMD_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= action_reg;
                if (action_reg)
                begin
                    out_data_reg <= {6'b0, ovf_reg, total_reg, 145'b0};
                    fill_reg     <= '0;
                    total_reg    <= '0;
                    ovf_reg      <= 1'b0;
                end
                else
                    out_data_reg <= {6'b0, ovf_reg, total_reg, !hit_found_reg, lb_reg,
                                     card_reg, hit_reg, sup_reg, mask_reg};
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.finish    = action_reg;
    assign status.excluded  = (mask_reg & excl_reg) != '0;
    assign status.n_zero    = (n_reg == '0);
    assign status.crit      = crit_reg;
    assign status.suff      = crit_reg ? (64'({y_reg, 30'b0}) >= mul_reg)
                                       : (n_reg != '0 && gate_ok_reg && lb_reg >= theta_reg);
    assign status.emit      = !monly_reg || !hit_found_reg;
    assign status.out_free  = out_free;
    assign status.div_done  = ddone_reg;
    assign status.sqrt_done = sq_done_reg;
    assign status.scan_done = sc_done_reg;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hdl/wilson_sufficiency_antichain_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// An excluded item returns to idle after its check, and a finish item goes
// straight to emitting the cell total. A kept item with nonzero support runs
// two long divisions (point criterion) or three (Wilson) and a square root. A
// sufficient item then adds the antichain scan, the store update and the
// result (in minimal-only mode, only for a minimal mask). A stalled output
// holds the block in its emit state until the output register is free.
// Throughput: one item at a time; the next item is taken once the block is
// idle, while the previous result may still wait in the output register.
// Reset: asynchronous, active low; control and configuration registers take
// their defaults; the cell state is empty at once, with no pass over the store.
// ----------------------------------------------------------------------------
// wilson_sufficiency_antichain_filter
// Sufficiency filter with a Wilson score lower bound and a greedy antichain
// of minimal masks for one cell.
// ----------------------------------------------------------------------------
module wilson_sufficiency_antichain_filter
    import wsaf_pkg::*;
#(
    parameter int MAX_MINIMAL = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    // Input items.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // item_mask[63:0], support[84:64], hits[105:85]
    input  logic                  s_tuser,   // action
    // Result items.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // row_mask[63:0], row_support[84:64],
                                             // row_hits[105:85], cardinality[112:106],
                                             // lower_bound[143:113], minimal[144],
                                             // sufficient_count[176:145], overflow[177]
    output logic                  m_tuser    // kind
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       in_accept;

    // Registers may be written at any time; the caller keeps writes to idle
    // periods, so the port never stalls.
    assign cfg_ready = 1'b1;

    // The sequencer only takes a new item from its idle state.
    assign s_tready  = cmd.idle;
    assign in_accept = s_tvalid && s_tready;

    wsaf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .status    (status),
        .cmd       (cmd)
    );

    wsaf_dp #(
        .MAX_MINIMAL (MAX_MINIMAL)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_accept  (in_accept),
        .in_action  (s_tuser),
        .in_mask    (s_tdata[63:0]),
        .in_support (s_tdata[84:64]),
        .in_hits    (s_tdata[105:85]),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_kind   (m_tuser),
        .out_data   (m_tdata)
    );

    // The arithmetic units and the scan run one after another, so at most one
    // of them reports completion in a cycle.
    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({status.div_done, status.sqrt_done, status.scan_done}))
        else $error("two datapath units finished in the same cycle");

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_tready)
        else $error("block ready right after taking an item");

    // A cell total carries zeros in every row field.
    a_total_zero_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[144:0] == '0))
        else $error("cell total with nonzero row fields");

    // A row result is always counted before it leaves.
    a_row_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[176:145] != '0))
        else $error("row result with zero sufficient count");

endmodule
